@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL file.
// Depends on a clk and an active-low arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that prop holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// assert that cond implies prop at the same edge
`define ASSERT_IMPLIES(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

@@ sv/pwh_pkg.sv @@
// Package for the polygon-with-holes point test: sizes, codes, types.
// No dependencies.
package pwh_pkg;

	localparam int MaxVertices = 1024;
	localparam int MaxRings    = 64;
	localparam int CoordBits   = 24;

	localparam int VtxAw    = $clog2(MaxVertices);
	localparam int VtxCntW  = $clog2(MaxVertices + 1);
	localparam int RingAw   = (MaxRings > 1) ? $clog2(MaxRings) : 1;
	localparam int RingCntW = $clog2(MaxRings + 1);
	localparam int DiffBits = CoordBits + 1;
	localparam int ProdBits = 2 * DiffBits;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_OPEN = 2'd2;

	typedef struct packed {
		logic              hole;
		logic [VtxAw-1:0]  last;
		logic [VtxAw-1:0]  first;
	} ring_entry_t;

	typedef struct packed {
		logic vld;
		logic seed;
		logic last;
		logic hole;
	} edge_tag_t;

	function automatic logic signed [DiffBits-1:0] sx(input logic [CoordBits-1:0] v);
		sx = signed'({v[CoordBits-1], v});
	endfunction

endpackage

@@ sv/polygon_with_holes_point_test.sv @@
// Point test against closed rings (outer outlines and holes) loaded vertex by vertex.
// Depends on pwh_pkg and assert_macros.svh.
//
// Clear and append items give their result in the cycle after they are accepted. A query
// walks the closed rings from the vertex memory, one edge per cycle through its single
// read port, reading each ring's last vertex first as the seed of the closing edge.
// One item is worked at a time; the result register lets the next item be taken in the
// cycle its result leaves. Vertex and ring memories need no clearing after reset.
module polygon_with_holes_point_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // vertex_x, vertex_y, point_x, point_y
	input  logic [2:0]  s_axis_tuser,  // func[1:0], is_hole
	input  logic        s_axis_tlast,  // closes_ring
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // inside_res, zero pad
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int CB = pwh_pkg::CoordBits;

	typedef enum logic [2:0] {S_IDLE, S_RING, S_LAST, S_WALK, S_DRAIN} state_t;

	state_t state_q;

	logic [CB-1:0] vertex_x, vertex_y, point_x, point_y;
	logic [1:0]    func;
	logic          is_hole, closes_ring, accept, out_free;

	assign vertex_x    = s_axis_tdata[CB-1:0];
	assign vertex_y    = s_axis_tdata[2*CB-1:CB];
	assign point_x     = s_axis_tdata[3*CB-1:2*CB];
	assign point_y     = s_axis_tdata[4*CB-1:3*CB];
	assign func        = s_axis_tuser[1:0];
	assign is_hole     = s_axis_tuser[2];
	assign closes_ring = s_axis_tlast;

	logic                           m_valid_q, inside_q;
	logic [1:0]                     status_q;
	logic [pwh_pkg::VtxCntW-1:0]    vtx_cnt_q, open_start_q;
	logic [pwh_pkg::RingCntW-1:0]   ring_cnt_q;
	logic [pwh_pkg::RingAw-1:0]     ring_idx_q;
	logic [pwh_pkg::VtxAw-1:0]      walk_idx_q, walk_last_q;
	logic                           walk_hole_q, odd_q, in_hole_q, in_outer_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, inside_q};
	assign m_axis_tuser  = status_q;

	// memories: no read and write in the same query, so no forwarding
	logic [2*CB-1:0]           vtx_mem [pwh_pkg::MaxVertices];
	pwh_pkg::ring_entry_t      ring_mem [pwh_pkg::MaxRings];
	logic [2*CB-1:0]           vtx_rd_q;
	pwh_pkg::ring_entry_t      ring_rd_q;
	logic [pwh_pkg::VtxAw-1:0] vtx_raddr;
	logic                      vtx_we, ring_we, full_drop;

	assign full_drop = (vtx_cnt_q >= pwh_pkg::VtxCntW'(pwh_pkg::MaxVertices)) ||
		(closes_ring && (ring_cnt_q >= pwh_pkg::RingCntW'(pwh_pkg::MaxRings)));
	assign vtx_we    = accept && (func == pwh_pkg::FUNC_APPEND) && !full_drop;
	assign ring_we   = vtx_we && closes_ring;

	always_ff @(posedge clk) begin
		if (vtx_we) begin
			vtx_mem[vtx_cnt_q[pwh_pkg::VtxAw-1:0]] <= {vertex_y, vertex_x};
		end
		vtx_rd_q <= vtx_mem[vtx_raddr];
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_cnt_q[pwh_pkg::RingAw-1:0]] <= '{hole: is_hole,
				last: vtx_cnt_q[pwh_pkg::VtxAw-1:0],
				first: open_start_q[pwh_pkg::VtxAw-1:0]};
		end
		ring_rd_q <= ring_mem[ring_idx_q];
	end

	// read issue
	pwh_pkg::edge_tag_t tag_a, tag_s1, tag_s2, tag_s3;

	always_comb begin
		vtx_raddr = walk_idx_q;
		tag_a     = '0;
		unique case (state_q)
			S_LAST: begin
				vtx_raddr = ring_rd_q.last;
				tag_a     = '{vld: 1'b1, seed: 1'b1, last: 1'b0, hole: 1'b0};
			end
			S_WALK: begin
				tag_a = '{vld: 1'b1, seed: 1'b0, last: (walk_idx_q == walk_last_q),
					hole: walk_hole_q};
			end
			default: begin
				tag_a = '0;
			end
		endcase
	end

	// edge datapath
	logic [CB-1:0]                       pt_x_q, pt_y_q;
	logic signed [pwh_pkg::DiffBits-1:0] ix, iy, jx_q, jy_q, px, py;
	logic signed [pwh_pkg::DiffBits-1:0] dpy_s2, dxj_s2, dpx_s2, dy_s2;
	logic signed [pwh_pkg::ProdBits-1:0] lhs_s3, rhs_s3;
	logic                                cand_s2, neg_s2, cand_s3, neg_s3, in_y, in_x, tgl;

	assign ix   = pwh_pkg::sx(vtx_rd_q[CB-1:0]);
	assign iy   = pwh_pkg::sx(vtx_rd_q[2*CB-1:CB]);
	assign px   = pwh_pkg::sx(pt_x_q);
	assign py   = pwh_pkg::sx(pt_y_q);
	assign in_y = ((iy <= py) && (jy_q >= py)) || ((jy_q <= py) && (iy >= py));
	assign in_x = (ix <= px) || (jx_q <= px);
	assign tgl  = cand_s3 && (neg_s3 ? (lhs_s3 > rhs_s3) : (lhs_s3 < rhs_s3));

	always_ff @(posedge clk) begin
		if (accept && (func == pwh_pkg::FUNC_QUERY)) begin
			pt_x_q <= point_x;
			pt_y_q <= point_y;
		end
		if (tag_s1.vld) begin
			jx_q <= ix;
			jy_q <= iy;
		end
		dpy_s2  <= py - iy;
		dxj_s2  <= jx_q - ix;
		dpx_s2  <= px - ix;
		dy_s2   <= jy_q - iy;
		cand_s2 <= tag_s1.vld && !tag_s1.seed && in_y && in_x && (jy_q != iy);
		neg_s2  <= jy_q < iy;
		lhs_s3  <= pwh_pkg::ProdBits'(dpy_s2) * pwh_pkg::ProdBits'(dxj_s2);
		rhs_s3  <= pwh_pkg::ProdBits'(dpx_s2) * pwh_pkg::ProdBits'(dy_s2);
		cand_s3 <= cand_s2;
		neg_s3  <= neg_s2;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_valid_q    <= 1'b0;
			inside_q     <= 1'b0;
			status_q     <= pwh_pkg::STATUS_OK;
			vtx_cnt_q    <= '0;
			ring_cnt_q   <= '0;
			open_start_q <= '0;
			ring_idx_q   <= '0;
			walk_idx_q   <= '0;
			walk_last_q  <= '0;
			walk_hole_q  <= 1'b0;
			odd_q        <= 1'b0;
			in_hole_q    <= 1'b0;
			in_outer_q   <= 1'b0;
			tag_s1       <= '0;
			tag_s2       <= '0;
			tag_s3       <= '0;
		end else begin
			tag_s1 <= tag_a;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (tag_s3.vld) begin
				if (tag_s3.last) begin
					odd_q <= 1'b0;
					if (odd_q ^ tgl) begin
						if (tag_s3.hole) begin
							in_hole_q <= 1'b1;
						end else begin
							in_outer_q <= 1'b1;
						end
					end
				end else begin
					odd_q <= odd_q ^ tgl;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						m_valid_q <= 1'b1;
						inside_q  <= 1'b0;
						status_q  <= pwh_pkg::STATUS_OK;
						case (func)
							pwh_pkg::FUNC_CLEAR: begin
								vtx_cnt_q    <= '0;
								ring_cnt_q   <= '0;
								open_start_q <= '0;
							end
							pwh_pkg::FUNC_APPEND: begin
								if (full_drop) begin
									status_q <= pwh_pkg::STATUS_FULL;
								end else begin
									vtx_cnt_q <= vtx_cnt_q + 1'b1;
									if (closes_ring) begin
										ring_cnt_q   <= ring_cnt_q + 1'b1;
										open_start_q <= vtx_cnt_q + 1'b1;
									end
								end
							end
							pwh_pkg::FUNC_QUERY: begin
								m_valid_q  <= 1'b0;
								ring_idx_q <= '0;
								odd_q      <= 1'b0;
								in_hole_q  <= 1'b0;
								in_outer_q <= 1'b0;
								state_q    <= (ring_cnt_q == '0) ? S_DRAIN : S_RING;
							end
							default: begin
								status_q <= pwh_pkg::STATUS_OK;
							end
						endcase
					end
				end
				S_RING: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					walk_idx_q  <= ring_rd_q.first;
					walk_last_q <= ring_rd_q.last;
					walk_hole_q <= ring_rd_q.hole;
					state_q     <= S_WALK;
				end
				S_WALK: begin
					walk_idx_q <= walk_idx_q + 1'b1;
					if (walk_idx_q == walk_last_q) begin
						if (({1'b0, ring_idx_q} + 1'b1) == pwh_pkg::RingCntW'(ring_cnt_q)) begin
							state_q <= S_DRAIN;
						end else begin
							ring_idx_q <= ring_idx_q + 1'b1;
							state_q    <= S_RING;
						end
					end
				end
				S_DRAIN: begin
					if (!tag_s1.vld && !tag_s2.vld && !tag_s3.vld && out_free) begin
						m_valid_q <= 1'b1;
						inside_q  <= in_outer_q && !in_hole_q;
						status_q  <= (vtx_cnt_q > open_start_q) ? pwh_pkg::STATUS_OPEN
							: pwh_pkg::STATUS_OK;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_vtx_cnt_bound, vtx_cnt_q <= pwh_pkg::VtxCntW'(pwh_pkg::MaxVertices), "vertex count past store depth")
	`ASSERT_ALWAYS(a_open_start_bound, open_start_q <= vtx_cnt_q, "open ring start past vertex count")
	`ASSERT_ALWAYS(a_ring_cnt_bound, ring_cnt_q <= pwh_pkg::RingCntW'(pwh_pkg::MaxRings), "ring count past table depth")
	`ASSERT_IMPLIES(a_pipe_idle, tag_s3.vld, state_q != S_IDLE, "edge in flight while idle")

endmodule
